// File: rtl/paged_frame_allocator_translate_top_macros.svh
// Assertion macros shared by the frame allocator checker.
`ifndef PAGED_FRAME_ALLOCATOR_TRANSLATE_TOP_MACROS_SVH
`define PAGED_FRAME_ALLOCATOR_TRANSLATE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define PFAT_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define PFAT_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// File: rtl/pfat_pkg.sv
// Constants, beat types and helpers for the paged frame allocator.
`default_nettype none

package pfat_pkg;

   localparam int NUM_FRAMES = 64;
   localparam int PID_BITS   = 8;

   localparam int FRAME_W = $clog2(NUM_FRAMES);
   localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
   localparam int FT_W    = PID_BITS + FRAME_W;

   // fixed field widths of the channels
   localparam int FUNC_W   = 2;
   localparam int PIDF_W   = 8;
   localparam int SIZE_W   = 23;
   localparam int ADDR_W   = 22;
   localparam int STATUS_W = 2;
   localparam int FRAMEF_W = 6;
   localparam int PAGEF_W  = 6;
   localparam int FREED_W  = 7;
   localparam int SHIFT_W  = 5;

   localparam int SUM_W    = SIZE_W + 1;
   localparam int SMASK_W  = 17;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd4;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_XLATE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FRAMES  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [PIDF_W-1:0] pid;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] virt_addr;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FRAMEF_W-1:0] frame;
      logic [PAGEF_W-1:0]  page_index;
      logic                frame_valid;
      logic [FREED_W-1:0]  freed_count;
      logic [ADDR_W-1:0]   physical_address;
      logic                last;
   } rsp_type;

   function automatic logic [FRAME_W-1:0] wrap_next(input logic [FRAME_W-1:0] p);
      return (p == FRAME_W'(NUM_FRAMES - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

`default_nettype wire

// File: rtl/pfat_req_if.sv
// Request channel: valid/ready handshake carrying one operation beat.
`default_nettype none

interface pfat_req_if;
   logic              valid;
   logic              ready;
   pfat_pkg::req_type data;

   modport source  (output valid, output data, input ready);
   modport sink    (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

`default_nettype wire

// File: rtl/pfat_rsp_if.sv
// Response channel: valid/ready handshake carrying one result beat.
`default_nettype none

interface pfat_rsp_if;
   logic              valid;
   logic              ready;
   pfat_pkg::rsp_type data;

   modport source  (output valid, output data, input ready);
   modport sink    (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

`default_nettype wire

// File: rtl/pfat_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module pfat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/paged_frame_allocator_translate_top.sv
// Paged frame allocator: free-frame FIFO, inverted frame table, translation.
//
//  channel  dir  beat contents                                  handshake
//  req_ch   in   func, pid, request_size, virt_addr             valid/ready
//  rsp_ch   out  status, frame, page_index, frame_valid,        valid/ready
//                freed_count, physical_address, last
//  csr      in   page_shift (5 bits)                            csr_we, no stall
//
// One operation at a time: a request is taken only in idle, then decoded.
// Allocate then emits one beat per page at one page per cycle while the
// output register can take it (free-FIFO RAM read of the next head overlaps
// the current pop). Free and translate scan the frame table RAM one entry
// per cycle; translate stops at the first hit and skips address zero.
// Reset is synchronous and needs no clearing pass: used bits and FIFO
// written bits are flops; an unwritten FIFO entry reads as its own index.
// A stalled response holds in the output register; the engine waits on it.
`default_nettype none

module paged_frame_allocator_translate_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [pfat_pkg::SHIFT_W-1:0] csr_wdata,
   pfat_req_if.sink                     req_ch,
   pfat_rsp_if.source                   rsp_ch
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_ALLOC  = 6'b000100,
      ST_FREE   = 6'b001000,
      ST_XLATE  = 6'b010000,
      ST_SEND   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [pfat_pkg::SHIFT_W-1:0] page_shift_ff, page_shift_in;
   logic [pfat_pkg::SHIFT_W-1:0] sh_eff;

   // captured request
   logic [pfat_pkg::FUNC_W-1:0]   func_ff,  func_in;
   logic [pfat_pkg::PID_BITS-1:0] pid_ff,   pid_in;
   logic [pfat_pkg::SIZE_W-1:0]   size_ff,  size_in;
   logic [pfat_pkg::ADDR_W-1:0]   addr_ff,  addr_in;

   // free-frame FIFO control and frame-used bits
   logic [pfat_pkg::FRAME_W-1:0]    head_ff, head_in;
   logic [pfat_pkg::FRAME_W-1:0]    tail_ff, tail_in;
   logic [pfat_pkg::CNT_W-1:0]      free_cnt_ff, free_cnt_in;
   logic [pfat_pkg::NUM_FRAMES-1:0] used_ff, used_in;
   logic [pfat_pkg::NUM_FRAMES-1:0] fifo_vld_ff, fifo_vld_in;

   // scan pipeline
   logic [pfat_pkg::CNT_W-1:0]   scan_ff, scan_in;
   logic                         chk_v_ff, chk_v_in;
   logic [pfat_pkg::FRAME_W-1:0] chk_idx_ff, chk_idx_in;
   logic [pfat_pkg::CNT_W-1:0]   freed_ff, freed_in;

   // allocate progress
   logic [pfat_pkg::FRAME_W-1:0] pg_ff, pg_in;
   logic [pfat_pkg::FRAME_W-1:0] pg_last_ff, pg_last_in;

   // translate split of the address
   logic [pfat_pkg::ADDR_W-1:0] xl_page_ff, xl_page_in;
   logic [pfat_pkg::ADDR_W-1:0] xl_off_ff,  xl_off_in;

   // single-beat result staging and output register
   pfat_pkg::rsp_type one_ff, one_in;
   pfat_pkg::rsp_type out_ff, out_in;
   logic              out_v_ff, out_v_in;
   logic              out_free;

   // RAM ports
   logic                         fifo_we;
   logic [pfat_pkg::FRAME_W-1:0] fifo_wa, fifo_wd, fifo_rd;
   logic                         ft_we;
   logic [pfat_pkg::FRAME_W-1:0] ft_wa;
   logic [pfat_pkg::FT_W-1:0]    ft_wd, ft_rd;

   // derived
   logic [pfat_pkg::FRAME_W-1:0]  pop_frame;
   logic [pfat_pkg::PID_BITS-1:0] ft_owner;
   logic [pfat_pkg::FRAME_W-1:0]  ft_page;
   logic                          owner_hit, xl_hit, scan_end;
   logic [pfat_pkg::SMASK_W-1:0]  size_mask;
   logic [pfat_pkg::SUM_W-1:0]    pages;
   logic [pfat_pkg::ADDR_W-1:0]   addr_mask;
   logic [pfat_pkg::CNT_W-1:0]    freed_nx;

   // clamp page shift to the meaningful range
   always_comb begin
      if (page_shift_ff < pfat_pkg::SHIFT_MIN) begin
         sh_eff = pfat_pkg::SHIFT_MIN;
      end else if (page_shift_ff > pfat_pkg::SHIFT_MAX) begin
         sh_eff = pfat_pkg::SHIFT_MAX;
      end else begin
         sh_eff = page_shift_ff;
      end
   end

   assign size_mask = (pfat_pkg::SMASK_W'(1) << sh_eff) - pfat_pkg::SMASK_W'(1);
   assign pages     = (pfat_pkg::SUM_W'(size_ff) + pfat_pkg::SUM_W'(size_mask)) >> sh_eff;
   assign addr_mask = (pfat_pkg::ADDR_W'(1) << sh_eff) - pfat_pkg::ADDR_W'(1);

   // never-written FIFO slot reads as its own index: frame == slot
   assign pop_frame = fifo_vld_ff[head_ff] ? fifo_rd : head_ff;

   assign ft_owner  = ft_rd[pfat_pkg::FRAME_W +: pfat_pkg::PID_BITS];
   assign ft_page   = ft_rd[pfat_pkg::FRAME_W-1:0];
   assign owner_hit = chk_v_ff && used_ff[chk_idx_ff] && (ft_owner == pid_ff);
   assign xl_hit    = owner_hit && (pfat_pkg::ADDR_W'(ft_page) == xl_page_ff);
   assign scan_end  = chk_v_ff && (chk_idx_ff == pfat_pkg::FRAME_W'(pfat_pkg::NUM_FRAMES - 1));
   assign freed_nx  = freed_ff + pfat_pkg::CNT_W'(owner_hit);

   assign out_free = !out_v_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.data  = out_ff;

   always_comb begin
      state_in      = state_ff;
      page_shift_in = csr_we ? csr_wdata : page_shift_ff;
      func_in       = func_ff;
      pid_in        = pid_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_cnt_in   = free_cnt_ff;
      used_in       = used_ff;
      fifo_vld_in   = fifo_vld_ff;
      scan_in       = scan_ff;
      chk_v_in      = 1'b0;
      chk_idx_in    = scan_ff[pfat_pkg::FRAME_W-1:0];
      freed_in      = freed_ff;
      pg_in         = pg_ff;
      pg_last_in    = pg_last_ff;
      xl_page_in    = xl_page_ff;
      xl_off_in     = xl_off_ff;
      one_in        = one_ff;
      out_in        = out_ff;
      out_v_in      = out_v_ff && !rsp_ch.ready;
      fifo_we       = 1'b0;
      fifo_wa       = tail_ff;
      fifo_wd       = chk_idx_ff;
      ft_we         = 1'b0;
      ft_wa         = pop_frame;
      ft_wd         = {pid_ff, pg_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               func_in  = req_ch.data.func;
               pid_in   = pfat_pkg::PID_BITS'(req_ch.data.pid);
               size_in  = req_ch.data.request_size;
               addr_in  = req_ch.data.virt_addr;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            one_in      = '0;
            one_in.last = 1'b1;
            scan_in     = '0;
            freed_in    = '0;
            pg_in       = '0;
            xl_page_in  = addr_ff >> sh_eff;
            xl_off_in   = addr_ff & addr_mask;
            state_in    = ST_SEND;
            case (func_ff)
               pfat_pkg::FUNC_ALLOC: begin
                  if (pages > pfat_pkg::SUM_W'(free_cnt_ff)) begin
                     one_in.status = pfat_pkg::ST_NO_FRAMES;
                  end else if (pages != '0) begin
                     pg_last_in = pfat_pkg::FRAME_W'(pages - pfat_pkg::SUM_W'(1));
                     state_in   = ST_ALLOC;
                  end
               end
               pfat_pkg::FUNC_FREE: begin
                  state_in = ST_FREE;
               end
               pfat_pkg::FUNC_XLATE: begin
                  if (addr_ff != '0) begin
                     state_in = ST_XLATE;
                  end
               end
               default: begin
                  state_in = ST_SEND;
               end
            endcase
         end

         ST_ALLOC: begin
            // one page per cycle while the output register can take it
            if (out_free) begin
               ft_we                = 1'b1;
               used_in[pop_frame]   = 1'b1;
               head_in              = pfat_pkg::wrap_next(head_ff);
               free_cnt_in          = free_cnt_ff - 1'b1;
               out_v_in             = 1'b1;
               out_in               = '0;
               out_in.status        = pfat_pkg::ST_OK;
               out_in.frame         = pfat_pkg::FRAMEF_W'(pop_frame);
               out_in.page_index    = pfat_pkg::PAGEF_W'(pg_ff);
               out_in.frame_valid   = 1'b1;
               out_in.last          = (pg_ff == pg_last_ff);
               pg_in                = pg_ff + 1'b1;
               if (pg_ff == pg_last_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_FREE: begin
            if (scan_ff < pfat_pkg::CNT_W'(pfat_pkg::NUM_FRAMES)) begin
               chk_v_in = 1'b1;
               scan_in  = scan_ff + 1'b1;
            end
            if (owner_hit) begin
               used_in[chk_idx_ff]     = 1'b0;
               fifo_we                 = 1'b1;
               fifo_vld_in[tail_ff]    = 1'b1;
               tail_in                 = pfat_pkg::wrap_next(tail_ff);
               free_cnt_in             = free_cnt_ff + 1'b1;
            end
            freed_in = freed_nx;
            if (scan_end) begin
               one_in.freed_count = pfat_pkg::FREED_W'(freed_nx);
               state_in           = ST_SEND;
            end
         end

         ST_XLATE: begin
            if (scan_ff < pfat_pkg::CNT_W'(pfat_pkg::NUM_FRAMES)) begin
               chk_v_in = 1'b1;
               scan_in  = scan_ff + 1'b1;
            end
            if (xl_hit) begin
               // offset is below the page size, so OR is the add
               one_in.physical_address =
                  (pfat_pkg::ADDR_W'(chk_idx_ff) << sh_eff) | xl_off_ff;
               state_in = ST_SEND;
            end else if (scan_end) begin
               one_in.status = pfat_pkg::ST_NOT_MAPPED;
               state_in      = ST_SEND;
            end
         end

         ST_SEND: begin
            if (out_free) begin
               out_v_in = 1'b1;
               out_in   = one_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         page_shift_ff <= pfat_pkg::SHIFT_RESET;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_cnt_ff   <= pfat_pkg::CNT_W'(pfat_pkg::NUM_FRAMES);
         used_ff       <= '0;
         fifo_vld_ff   <= '0;
         chk_v_ff      <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         page_shift_ff <= page_shift_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_cnt_ff   <= free_cnt_in;
         used_ff       <= used_in;
         fifo_vld_ff   <= fifo_vld_in;
         chk_v_ff      <= chk_v_in;
         out_v_ff      <= out_v_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      pid_ff     <= pid_in;
      size_ff    <= size_in;
      addr_ff    <= addr_in;
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      freed_ff   <= freed_in;
      pg_ff      <= pg_in;
      pg_last_ff <= pg_last_in;
      xl_page_ff <= xl_page_in;
      xl_off_ff  <= xl_off_in;
      one_ff     <= one_in;
      out_ff     <= out_in;
   end

   // free-frame FIFO; read address follows the next head so the registered
   // read data belongs to the current head
   pfat_ram #(
      .WIDTH (pfat_pkg::FRAME_W),
      .DEPTH (pfat_pkg::NUM_FRAMES)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_wa),
      .wr_data (fifo_wd),
      .rd_addr (head_in),
      .rd_data (fifo_rd)
   );

   // frame table: owner pid and page per frame
   pfat_ram #(
      .WIDTH (pfat_pkg::FT_W),
      .DEPTH (pfat_pkg::NUM_FRAMES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ft_we),
      .wr_addr (ft_wa),
      .wr_data (ft_wd),
      .rd_addr (scan_ff[pfat_pkg::FRAME_W-1:0]),
      .rd_data (ft_rd)
   );

endmodule

`default_nettype wire

// File: rtl/pfat_checker.sv
// Port-level checker for the frame allocator, bound to the top level.
`default_nettype none
`include "paged_frame_allocator_translate_top_macros.svh"

module pfat_checker (
   input logic        clock,
   input logic        reset,
   pfat_req_if.sink   req_ch,
   pfat_rsp_if.source rsp_ch
);

   `PFAT_ASSERT_NEXT(a_rsp_hold, rsp_ch.valid && !rsp_ch.ready, rsp_ch.valid && $stable(rsp_ch.data), "response beat changed while stalled")
   `PFAT_ASSERT_NEXT(a_one_at_a_time, req_ch.valid && req_ch.ready, !req_ch.ready, "request taken while busy")
   `PFAT_ASSERT_NOW(a_assign_clean, rsp_ch.valid && rsp_ch.data.frame_valid, rsp_ch.data.status == pfat_pkg::ST_OK && rsp_ch.data.freed_count == '0 && rsp_ch.data.physical_address == '0, "assignment beat carries other fields")
   `PFAT_ASSERT_NOW(a_error_single, rsp_ch.valid && rsp_ch.data.status != pfat_pkg::ST_OK, rsp_ch.data.last && !rsp_ch.data.frame_valid && rsp_ch.data.physical_address == '0, "error beat not a lone final beat")

endmodule

bind paged_frame_allocator_translate_top pfat_checker u_pfat_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking bench for the paged frame allocator: directed and random ops.
`default_nettype none

module tb_top;

   // op code with no meaning; the block must answer with one beat, zero but for last
   localparam logic [pfat_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // generous bound: far above the run length of all ops with worst-case stalls
   localparam int CYCLE_LIMIT = 1000000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_we;
   logic [pfat_pkg::SHIFT_W-1:0]  csr_wdata;

   pfat_req_if req_ch ();
   pfat_rsp_if rsp_ch ();

   paged_frame_allocator_translate_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // 8-unit clock period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the allocator state. Updated when an op beat is
   // accepted on the request channel, so it always runs in beat order.
   // ------------------------------------------------------------------
   logic [pfat_pkg::SHIFT_W-1:0] shift_reg;                      // last csr value
   logic [pfat_pkg::FRAME_W-1:0] free_ring  [pfat_pkg::NUM_FRAMES]; // free-frame FIFO
   logic [pfat_pkg::FRAME_W-1:0] ring_head;                      // pop side
   logic [pfat_pkg::FRAME_W-1:0] ring_tail;                      // fill side
   int unsigned                  frames_free;
   logic                         frame_busy [pfat_pkg::NUM_FRAMES];
   logic [pfat_pkg::PIDF_W-1:0]  frame_pid  [pfat_pkg::NUM_FRAMES];
   logic [pfat_pkg::PAGEF_W-1:0] frame_pg   [pfat_pkg::NUM_FRAMES];

   pfat_pkg::rsp_type due_results [$];   // result beats still owed by the block
   pfat_pkg::req_type pending_ops [$];   // op beats not yet handed to the driver
   logic       op_holding;        // driver has an op on the bus, not yet taken
   logic       idle_on;           // random gaps/stalls enabled
   int         req_gap;
   int         rsp_gap;
   int         cycle_count;
   int         err_count;

   logic [pfat_pkg::PIDF_W-1:0] pid_pool [6] = '{8'd3, 8'd17, 8'd64, 8'd128, 8'd200, 8'd255};

   // out-of-range page shifts saturate to 4..16
   function automatic int unsigned clamp_shift(input logic [pfat_pkg::SHIFT_W-1:0] v);
      if (v < pfat_pkg::SHIFT_MIN) return pfat_pkg::SHIFT_MIN;
      if (v > pfat_pkg::SHIFT_MAX) return pfat_pkg::SHIFT_MAX;
      return v;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      err_count++;
   endtask

   // Work out the beats one op produces and queue them; update shadow state.
   task automatic apply_frame_op(input pfat_pkg::req_type op);
      int unsigned sh;
      int unsigned pages;
      int unsigned page;
      int unsigned off;
      int unsigned n;
      int unsigned i;
      logic [pfat_pkg::FRAME_W-1:0] f;
      pfat_pkg::rsp_type r;
      sh = clamp_shift(shift_reg);
      r = '0;
      r.last = 1'b1;
      case (op.func)
         pfat_pkg::FUNC_ALLOC: begin
            // round up to whole pages
            pages = (int'(op.request_size) + (1 << sh) - 1) >> sh;
            if (pages > frames_free) begin
               // not enough room: nothing changes
               r.status = pfat_pkg::ST_NO_FRAMES;
               due_results.insert(due_results.size(), r);
            end else if (pages == 0) begin
               // zero-size request: one ok beat with no frame
               due_results.insert(due_results.size(), r);
            end else begin
               for (i = 0; i < pages; i++) begin
                  f = free_ring[ring_head];
                  ring_head++;
                  frames_free--;
                  frame_busy[f] = 1'b1;
                  frame_pid[f]  = op.pid;
                  frame_pg[f]   = pfat_pkg::PAGEF_W'(i);
                  r.frame       = f;
                  r.page_index  = pfat_pkg::PAGEF_W'(i);
                  r.frame_valid = 1'b1;
                  r.last        = (i + 1 == pages);
                  due_results.insert(due_results.size(), r);
               end
            end
         end
         pfat_pkg::FUNC_FREE: begin
            // release in ascending frame order onto the FIFO tail
            n = 0;
            for (i = 0; i < pfat_pkg::NUM_FRAMES; i++) begin
               if (frame_busy[i] && frame_pid[i] == op.pid) begin
                  frame_busy[i] = 1'b0;
                  free_ring[ring_tail] = pfat_pkg::FRAME_W'(i);
                  ring_tail++;
                  frames_free++;
                  n++;
               end
            end
            r.freed_count = pfat_pkg::FREED_W'(n);
            due_results.insert(due_results.size(), r);
         end
         pfat_pkg::FUNC_XLATE: begin
            // address zero answers zero, mapped or not
            if (op.virt_addr != '0) begin
               page = op.virt_addr >> sh;
               off  = op.virt_addr & ((1 << sh) - 1);
               r.status = pfat_pkg::ST_NOT_MAPPED;
               // lowest matching frame wins when a page is held twice
               for (i = 0; i < pfat_pkg::NUM_FRAMES && r.status == pfat_pkg::ST_NOT_MAPPED;
                    i++) begin
                  if (frame_busy[i] && frame_pid[i] == op.pid && frame_pg[i] == page) begin
                     r.status = pfat_pkg::ST_OK;
                     r.physical_address = pfat_pkg::ADDR_W'((i << sh) + off);
                  end
               end
            end
            due_results.insert(due_results.size(), r);
         end
         default: due_results.insert(due_results.size(), r);
      endcase
   endtask

   // ------------------------------------------------------------------
   // Request driver: feeds ops from pending_ops, with random gaps.
   // An op handed over is fed to the shadow model at its accepting edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      pfat_pkg::req_type next_op;
      logic              next_valid;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data  <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            apply_frame_op(req_ch.data);
            op_holding = 1'b0;
         end
         next_valid = 1'b0;
         next_op    = req_ch.data;
         if (pending_ops.size() != 0) begin
            if (req_gap != 0) begin
               req_gap--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
               // random gap before the next op, this cycle included
               req_gap = $urandom_range(0, 8);
            end else begin
               next_valid = 1'b1;
               next_op    = pending_ops[0];
               pending_ops.delete(0);
               op_holding = 1'b1;
            end
         end
         req_ch.valid <= next_valid;
         req_ch.data  <= next_op;
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: checks every accepted beat against the oldest one due,
   // and throttles ready in random bursts.
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin
      pfat_pkg::rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("unexpected beat 0x%0h", rsp_ch.data));
            end else begin
               want = due_results[0];
               due_results.delete(0);
               check_field("status",           rsp_ch.data.status,           want.status);
               check_field("frame",            rsp_ch.data.frame,            want.frame);
               check_field("page_index",       rsp_ch.data.page_index,       want.page_index);
               check_field("frame_valid",      rsp_ch.data.frame_valid,      want.frame_valid);
               check_field("freed_count",      rsp_ch.data.freed_count,      want.freed_count);
               check_field("physical_address", rsp_ch.data.physical_address,
                           want.physical_address);
               check_field("last",             rsp_ch.data.last,             want.last);
            end
         end
         if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(0, 8);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic add_op(input logic [31:0] func, input logic [31:0] pid,
                         input logic [31:0] size, input logic [31:0] addr);
      pfat_pkg::req_type op;
      op.func         = pfat_pkg::FUNC_W'(func);
      op.pid          = pfat_pkg::PIDF_W'(pid);
      op.request_size = pfat_pkg::SIZE_W'(size);
      op.virt_addr    = pfat_pkg::ADDR_W'(addr);
      pending_ops.insert(pending_ops.size(), op);
   endtask

   // block is idle once nothing is queued, on the bus, or owed back
   task automatic wait_drain();
      do
         @(posedge clock);
      while (pending_ops.size() != 0 || op_holding || due_results.size() != 0);
   endtask

   // csr write; only called with the block drained
   task automatic set_page_shift(input logic [pfat_pkg::SHIFT_W-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      shift_reg  = v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly well-formed sessions: allocate, translate inside (or just past)
   // the pages, sometimes free. The rest are frees of pool pids or random ops.
   task automatic random_phase(input int n_ops);
      int unsigned sh;
      int unsigned pages;
      int unsigned pid;
      int unsigned pg;
      int unsigned k;
      int          stop_at;
      bit          stray;
      sh = clamp_shift(shift_reg);
      stop_at = pending_ops.size() + n_ops;
      while (pending_ops.size() < stop_at) begin
         k = $urandom_range(0, 9);
         if (k < 6) begin
            stray = ($urandom_range(0, 7) == 0);
            pid   = stray ? $urandom_range(0, 255) : pid_pool[$urandom_range(0, 5)];
            pages = $urandom_range(1, 6);
            add_op(pfat_pkg::FUNC_ALLOC, pid,
                   ((pages - 1) << sh) + $urandom_range(1, 1 << sh), $urandom);
            repeat ($urandom_range(0, 3)) begin
               pg = $urandom_range(0, pages);
               add_op(pfat_pkg::FUNC_XLATE, pid, $urandom,
                      (pg << sh) | ($urandom & ((1 << sh) - 1)));
            end
            // stray pids are always returned so frames do not leak away
            if (stray || $urandom_range(0, 2) == 0)
               add_op(pfat_pkg::FUNC_FREE, pid, $urandom, $urandom);
         end else if (k < 8) begin
            add_op(pfat_pkg::FUNC_FREE, pid_pool[$urandom_range(0, 5)], $urandom, $urandom);
         end else begin
            pid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                              : pid_pool[$urandom_range(0, 5)];
            add_op($urandom_range(0, 3), pid, $urandom, $urandom);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      int unsigned i;
      logic [pfat_pkg::SHIFT_W-1:0] shifts [8];

      shifts        = '{5'd4, 5'd31, 5'd16, 5'd2, 5'd9, 5'd0, 5'd20, 5'd12};
      req_ch.valid  = 1'b0;
      req_ch.data   = '0;
      rsp_ch.ready  = 1'b0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      op_holding    = 1'b0;
      idle_on       = 1'b1;
      req_gap       = 0;
      rsp_gap       = 0;
      cycle_count   = 0;
      err_count     = 0;

      // shadow state after reset: FIFO holds frames in order, all free
      shift_reg   = pfat_pkg::SHIFT_RESET;
      ring_head   = '0;
      ring_tail   = '0;
      frames_free = pfat_pkg::NUM_FRAMES;
      for (i = 0; i < pfat_pkg::NUM_FRAMES; i++) begin
         free_ring[i]  = pfat_pkg::FRAME_W'(i);
         frame_busy[i] = 1'b0;
         frame_pid[i]  = '0;
         frame_pg[i]   = '0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset page size (4 KiB).
      add_op(pfat_pkg::FUNC_ALLOC, 0,   0,       0);          // zero-size request
      add_op(pfat_pkg::FUNC_ALLOC, 255, 1,       0);          // one byte -> one page
      add_op(pfat_pkg::FUNC_ALLOC, 1,   12288,   0);          // exact multiple: 3 pages
      add_op(pfat_pkg::FUNC_ALLOC, 1,   4097,    0);          // rounds up to 2; page 0 twice
      add_op(pfat_pkg::FUNC_ALLOC, 2,   4194304, 0);          // 4 MiB: too many pages
      add_op(pfat_pkg::FUNC_XLATE, 1,   0,       0);          // address zero
      add_op(pfat_pkg::FUNC_XLATE, 1,   0,       22'h3fffff); // largest address, unmapped
      add_op(pfat_pkg::FUNC_XLATE, 1,   0,       4096 + 5);   // page 1 held twice, low frame
      add_op(pfat_pkg::FUNC_XLATE, 255, 0,       12'hfff);    // last byte of a page
      add_op(pfat_pkg::FUNC_XLATE, 3,   0,       100);        // pid owns nothing
      add_op(FUNC_UNUSED, 8'haa, 23'h7fffff, 22'h3fffff);
      add_op(pfat_pkg::FUNC_FREE,  9,   0,       0);          // nothing to free
      add_op(pfat_pkg::FUNC_FREE,  1,   0,       0);          // five frames back on the FIFO
      add_op(pfat_pkg::FUNC_XLATE, 1,   0,       4096);       // gone after the free
      add_op(pfat_pkg::FUNC_ALLOC, 200, 63 * 4096, 0);        // take every free frame, FIFO wraps
      add_op(pfat_pkg::FUNC_ALLOC, 3,   1,       0);          // none left
      add_op(pfat_pkg::FUNC_ALLOC, 3,   0,       0);          // zero-size still ok when full
      add_op(pfat_pkg::FUNC_XLATE, 200, 0,       (62 << 12) | 12'hfff);
      add_op(pfat_pkg::FUNC_FREE,  200, 0,       0);
      add_op(pfat_pkg::FUNC_FREE,  255, 0,       0);
      add_op(pfat_pkg::FUNC_ALLOC, 77,  64 * 4096, 0);        // all 64 frames, longest burst
      add_op(pfat_pkg::FUNC_XLATE, 77,  0,       (63 << 12) + 1);
      add_op(pfat_pkg::FUNC_FREE,  77,  0,       0);          // releases 64
      wait_drain();

      // Random phases across page sizes, clamped values included.
      // Last phase runs with no gaps or stalls.
      for (i = 0; i < 8; i++) begin
         set_page_shift(shifts[i]);
         if (i == 7)
            idle_on = 1'b0;
         random_phase(31);
         wait_drain();
      end

      // catch any stray beats after the last one due
      repeat (pfat_pkg::NUM_FRAMES + 8) @(posedge clock);
      if (err_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
